>>> hdl/mft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft_pkg
// Shared codes, field widths and constants of the Manchester frame transceiver.
// ----------------------------------------------------------------------------
package mft_pkg;

  // Command codes carried in the input tuser.
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_LISTEN = 2'd1;
  localparam logic [1:0] FUNC_SEND   = 2'd2;
  localparam logic [1:0] FUNC_STOP   = 2'd3;

  // Operating modes.
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_LISTEN   = 3'd1;
  localparam logic [2:0] MODE_READ     = 3'd2;
  localparam logic [2:0] MODE_RECEIVED = 3'd3;
  localparam logic [2:0] MODE_WRITE    = 3'd4;
  localparam logic [2:0] MODE_SENT     = 3'd5;
  localparam logic [2:0] MODE_PERR     = 3'd6;
  localparam logic [2:0] MODE_TIMEOUT  = 3'd7;

  // Fault codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_MID    = 3'd1;
  localparam logic [2:0] ERR_BAD_STOP  = 3'd2;
  localparam logic [2:0] ERR_PARITY    = 3'd3;
  localparam logic [2:0] ERR_IDLE_LONG = 3'd4;

  // Frame and timing constants.
  localparam int unsigned TICKS_PER_MS = 5;
  localparam int unsigned TIMEOUT_W    = 19;
  localparam int unsigned PRODUCT_W    = 24;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = {TIMEOUT_W{1'b1}};
  localparam logic [5:0] STOP_POS  = 6'd32;
  localparam logic [5:0] START_POS = 6'd33;
  localparam logic [5:0] BIT_POS_MAX = 6'd33;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 1;
  localparam int unsigned CFG_W       = 16;
  localparam logic [CFG_W-1:0] TIMEOUT_MS_RESET = 16'd800;

endpackage : mft_pkg
`default_nettype wire

>>> hdl/manchester_frame_transceiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// manchester_frame_transceiver_unit
// Half-duplex Manchester transceiver for 32-bit even-parity frames, driven by
// one command transaction per tick, listen, send or stop request.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                                   | tuser
//  in_     | slave     | line_in, msg_type, msg_id, value bytes  | func
//  out_    | master    | line_out, mode, error, bit pos, rx data | message_valid
//  cfg_    | write     | timeout_ms                              | -
//
//  Each command is handled in the update stage; a new transaction is
//  taken in every cycle while the result register drains.
//  An accepted transaction is registered in the input register, and its
//  result is registered in the output register once that one can advance.
//  Reset is synchronous, active low, and returns the control state to idle.
//  A stalled result holds in the output register, and the input register
//  keeps one more transaction until it can move on.
// ----------------------------------------------------------------------------
module manchester_frame_transceiver_unit
  import mft_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data,   // timeout_ms
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // line_in[0], msg_type[3:1], msg_id[11:4], value_high[19:12], value_low[27:20]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,      // func[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // line_out[0], mode[3:1], error_code[6:4], bit_position[12:7], rx_type[15:13],
  // rx_id[23:16], rx_value_high[31:24], rx_value_low[39:32]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [OUT_TUSER_W-1:0]      out_tuser      // message_valid[0]
);

  logic [CFG_W-1:0]       timeout_ms_r;

  logic                   in_valid_r;
  logic [IN_TDATA_W-1:0]  in_data_r;
  logic [IN_TUSER_W-1:0]  in_user_r;
  logic                   advance;

  logic [2:0]             op_mode_r, op_mode_nxt;
  logic [2:0]             fault_r, fault_nxt;
  logic [8:0]             hist_r, hist_nxt;
  logic                   half_r, half_nxt;
  logic [31:0]            frame_r, frame_nxt;
  logic [5:0]             bitcnt_r, bitcnt_nxt;
  logic [TIMEOUT_W-1:0]   tleft_r, tleft_nxt;
  logic                   drive_r, drive_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;

  logic                   line_in;
  logic [2:0]             msg_type;
  logic [7:0]             msg_id;
  logic [7:0]             value_high;
  logic [7:0]             value_low;
  logic [31:0]            tx_frame;
  logic [PRODUCT_W-1:0]   timeout_product;
  logic [TIMEOUT_W-1:0]   timeout_load;
  logic [5:0]             bitcnt_m1;
  logic                   tx_bit;
  logic                   prev_level;
  logic                   long_gap;
  logic                   msg_valid;
  logic [2:0]             err_out;

  assign line_in    = in_data_r[0];
  assign msg_type   = in_data_r[3:1];
  assign msg_id     = in_data_r[11:4];
  assign value_high = in_data_r[19:12];
  assign value_low  = in_data_r[27:20];

  // The update stage moves when the result register is free or being emptied.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    tx_frame = {1'b0, msg_type, 4'b0000, msg_id, value_high, value_low};
    // Bit 31 evens out an odd count of ones.
    if (^tx_frame) begin
      tx_frame[31] = 1'b1;
    end
  end

  assign timeout_product = PRODUCT_W'(timeout_ms_r) * PRODUCT_W'(TICKS_PER_MS);
  assign timeout_load = (timeout_product > PRODUCT_W'(TIMEOUT_MAX)) ? TIMEOUT_MAX
                        : timeout_product[TIMEOUT_W-1:0];

  assign bitcnt_m1  = bitcnt_r - 6'd1;
  assign tx_bit     = ((bitcnt_r == START_POS) || (bitcnt_r == 6'd0)) ? 1'b1
                      : frame_r[bitcnt_m1[4:0]];
  assign prev_level = hist_r[0];
  assign long_gap   = |hist_r[8:4];

  always_comb begin
    op_mode_nxt = op_mode_r;
    fault_nxt   = fault_r;
    hist_nxt    = hist_r;
    half_nxt    = half_r;
    frame_nxt   = frame_r;
    bitcnt_nxt  = bitcnt_r;
    tleft_nxt   = tleft_r;
    drive_nxt   = drive_r;

    unique case (in_user_r)
      FUNC_TICK: begin
        unique case (op_mode_r)
          MODE_LISTEN: begin
            if (tleft_r == '0) begin
              op_mode_nxt = MODE_TIMEOUT;
            end else begin
              if (line_in) begin
                frame_nxt   = '0;
                bitcnt_nxt  = '0;
                op_mode_nxt = MODE_READ;
                hist_nxt    = 9'd1;
                half_nxt    = 1'b1;
              end
              tleft_nxt = tleft_r - TIMEOUT_W'(1);
            end
          end
          MODE_READ: begin
            if (line_in != prev_level) begin
              if (half_r && long_gap) begin
                op_mode_nxt = MODE_PERR;
                fault_nxt   = ERR_NO_MID;
              end else if (half_r || long_gap) begin
                if (bitcnt_r == STOP_POS) begin
                  if (!prev_level) begin
                    op_mode_nxt = MODE_PERR;
                    fault_nxt   = ERR_BAD_STOP;
                  end else if (!(^frame_r)) begin
                    op_mode_nxt = MODE_RECEIVED;
                  end else begin
                    op_mode_nxt = MODE_PERR;
                    fault_nxt   = ERR_PARITY;
                  end
                end else begin
                  frame_nxt  = {frame_r[30:0], prev_level};
                  bitcnt_nxt = bitcnt_r + 6'd1;
                  half_nxt   = 1'b0;
                  hist_nxt   = {7'd0, 1'b1, line_in};
                end
              end else begin
                half_nxt = 1'b1;
                hist_nxt = {7'd0, 1'b1, line_in};
              end
            end else if (hist_r[8]) begin
              op_mode_nxt = MODE_PERR;
              fault_nxt   = ERR_IDLE_LONG;
            end else begin
              hist_nxt = {hist_r[7:0], line_in};
            end
          end
          MODE_WRITE: begin
            // First half of a bit drives its inverse, the second half the bit.
            drive_nxt = half_r ? !tx_bit : tx_bit;
            if (!half_r) begin
              if (bitcnt_r == 6'd0) begin
                op_mode_nxt = MODE_SENT;
              end else begin
                bitcnt_nxt = bitcnt_r - 6'd1;
              end
              half_nxt = 1'b1;
            end else begin
              half_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      FUNC_LISTEN: begin
        tleft_nxt   = timeout_load;
        op_mode_nxt = MODE_LISTEN;
        frame_nxt   = '0;
        bitcnt_nxt  = '0;
      end
      FUNC_SEND: begin
        frame_nxt   = tx_frame;
        half_nxt    = 1'b1;
        bitcnt_nxt  = START_POS;
        op_mode_nxt = MODE_WRITE;
      end
      FUNC_STOP: begin
        op_mode_nxt = MODE_IDLE;
      end
    endcase
  end

  assign msg_valid = (op_mode_nxt == MODE_RECEIVED);
  assign err_out   = (op_mode_nxt == MODE_PERR) ? fault_nxt : ERR_NONE;

  always_comb begin
    out_user_nxt = msg_valid;
    out_data_nxt = {
      msg_valid ? frame_nxt[7:0]   : 8'd0,
      msg_valid ? frame_nxt[15:8]  : 8'd0,
      msg_valid ? frame_nxt[23:16] : 8'd0,
      msg_valid ? frame_nxt[30:28] : 3'd0,
      bitcnt_nxt,
      err_out,
      op_mode_nxt,
      drive_nxt
    };
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ms_r <= TIMEOUT_MS_RESET;
    end else if (cfg_wr_en) begin
      timeout_ms_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_user_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r   <= MODE_IDLE;
      fault_r     <= ERR_NONE;
      hist_r      <= '0;
      half_r      <= 1'b0;
      frame_r     <= '0;
      bitcnt_r    <= '0;
      tleft_r     <= '0;
      drive_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (advance && in_valid_r) begin
        op_mode_r <= op_mode_nxt;
        fault_r   <= fault_nxt;
        hist_r    <= hist_nxt;
        half_r    <= half_nxt;
        frame_r   <= frame_nxt;
        bitcnt_r  <= bitcnt_nxt;
        tleft_r   <= tleft_nxt;
        drive_r   <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule : manchester_frame_transceiver_unit
`default_nettype wire

>>> hdl/mft_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mft_checker
// Port-level checks of the Manchester frame transceiver, bound to its top level.
// ----------------------------------------------------------------------------
module mft_checker
  import mft_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   cfg_wr_en,
  input wire logic [CFG_W-1:0]       cfg_wr_data,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic [IN_TUSER_W-1:0]  in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  // A stalled result must hold until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The message flag follows the received mode exactly.
  a_valid_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tdata[3:1] == MODE_RECEIVED)))
    else $error("message flag disagrees with mode");

  // Without a message the received fields stay clear.
  a_rx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[39:13] == '0))
    else $error("received fields set without a message");

  // An error code is only shown in the protocol error mode.
  a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:1] != MODE_PERR) |-> (out_tdata[6:4] == ERR_NONE))
    else $error("error code outside protocol error");

  // The bit counter never passes the start bit position.
  a_bitpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:7] <= BIT_POS_MAX))
    else $error("bit position out of range");

endmodule : mft_checker

bind manchester_frame_transceiver_unit mft_checker u_mft_checker (.*);
`default_nettype wire
